FILE: sv/running_regression_stats_core_defines.svh
// Assertion macros for the regression statistics core.
`ifndef RUNNING_REGRESSION_STATS_CORE_DEFINES_SVH
`define RUNNING_REGRESSION_STATS_CORE_DEFINES_SVH

// Overlapping implication, checked on the rising clock edge while out of reset.
`define RRS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rrs assertion failed");

// Implication into the next cycle.
`define RRS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rrs assertion failed");

`endif

FILE: sv/rrs_pkg.sv
package rrs_pkg;

    localparam int COUNT_BITS_DEF  = 24;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int CNT_OUT_W  = 24;
    localparam int MEAN_W     = 24;
    localparam int VAR_W      = 31;
    localparam int SD_W       = 24;
    localparam int COV_W      = 32;
    localparam int CORR_W     = 18;
    localparam int REG_W      = 32;
    localparam int STATUS_W   = 2;

    localparam int WORK_W     = 64;
    localparam int DEN_W      = 32;
    localparam int DIV_STEPS  = WORK_W;
    localparam int SQRT_STEPS = WORK_W / 2;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t STATUS_OK     = 2'd0;
    localparam status_t STATUS_VX_ZERO = 2'd1;
    localparam status_t STATUS_VY_ZERO = 2'd2;
    localparam status_t STATUS_FULL   = 2'd3;

    localparam logic signed [65:0] VAR_MAX  = 66'sd1073741824;
    localparam logic signed [65:0] CORR_MAX = 66'sd65536;
    localparam logic signed [65:0] I32_MAX  = 66'sd2147483647;
    localparam logic signed [65:0] I32_MIN  = -66'sd2147483648;

    function automatic logic signed [65:0] clamp66(input logic signed [65:0] v,
                                                   input logic signed [65:0] lo,
                                                   input logic signed [65:0] hi);
        logic signed [65:0] r;
        r = v;
        if (v < lo) r = lo;
        if (v > hi) r = hi;
        return r;
    endfunction

endpackage

FILE: sv/running_regression_stats_core.sv
// Each item is accumulated, then worked through by the shared divide/root unit: up to seven
// divisions and three square roots per item. The correlation root and division are skipped
// with fewer than two samples or a zero variance, and the slope division when the x variance
// is zero.
// s_ready is high only while the sequencer idles, so no new item is taken until the last is done.
// Reset: synchronous active-low aresetn clears the count, all sums and the handshakes.
`include "running_regression_stats_core_defines.svh"

module running_regression_stats_core #(
    parameter int COUNT_BITS  = rrs_pkg::COUNT_BITS_DEF,
    parameter int SAMPLE_BITS = rrs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [SAMPLE_BITS-1:0]        s_sample_x,
    input  logic signed [SAMPLE_BITS-1:0]        s_sample_y,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [rrs_pkg::CNT_OUT_W-1:0]        m_sample_count,
    output logic signed [rrs_pkg::MEAN_W-1:0]    m_mean_x,
    output logic signed [rrs_pkg::MEAN_W-1:0]    m_mean_y,
    output logic [rrs_pkg::VAR_W-1:0]            m_variance_x,
    output logic [rrs_pkg::VAR_W-1:0]            m_variance_y,
    output logic [rrs_pkg::SD_W-1:0]             m_stdev_x,
    output logic [rrs_pkg::SD_W-1:0]             m_stdev_y,
    output logic signed [rrs_pkg::COV_W-1:0]     m_covariance,
    output logic signed [rrs_pkg::CORR_W-1:0]    m_correlation,
    output logic signed [rrs_pkg::REG_W-1:0]     m_slope,
    output logic signed [rrs_pkg::REG_W-1:0]     m_intercept,
    output rrs_pkg::status_t                     m_status
);
    import rrs_pkg::*;

    localparam int SX_W  = SAMPLE_BITS + COUNT_BITS;
    localparam int SXX_W = 2 * SAMPLE_BITS + COUNT_BITS;
    localparam int IT_W  = $clog2(DIV_STEPS);

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_ACC0 = 5'd1;
    localparam logic [4:0] ST_ACC1 = 5'd2;
    localparam logic [4:0] ST_ACC2 = 5'd3;
    localparam logic [4:0] ST_ACC3 = 5'd4;
    localparam logic [4:0] ST_S1   = 5'd5;
    localparam logic [4:0] ST_S2   = 5'd6;
    localparam logic [4:0] ST_S3   = 5'd7;
    localparam logic [4:0] ST_S4   = 5'd8;
    localparam logic [4:0] ST_S5   = 5'd9;
    localparam logic [4:0] ST_S6   = 5'd10;
    localparam logic [4:0] ST_S7   = 5'd11;
    localparam logic [4:0] ST_S8   = 5'd12;
    localparam logic [4:0] ST_S9   = 5'd13;
    localparam logic [4:0] ST_S10  = 5'd14;
    localparam logic [4:0] ST_S11  = 5'd15;
    localparam logic [4:0] ST_S12  = 5'd16;
    localparam logic [4:0] ST_S13  = 5'd17;
    localparam logic [4:0] ST_S14  = 5'd18;
    localparam logic [4:0] ST_DIV  = 5'd19;
    localparam logic [4:0] ST_SQRT = 5'd20;
    localparam logic [4:0] ST_DONE = 5'd21;

    logic [4:0]                    state_reg, ret_reg;
    logic [COUNT_BITS-1:0]         cnt_reg;
    logic signed [SX_W-1:0]        sum_x_reg, sum_y_reg;
    logic signed [SXX_W-1:0]       sum_xx_reg, sum_yy_reg, sum_xy_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg, y_reg;
    logic                          full_reg;

    logic signed [MEAN_W-1:0]      mx_reg, my_reg;
    logic [VAR_W-1:0]              vx_reg, vy_reg;
    logic [SD_W-1:0]               sx_reg, sy_reg;
    logic signed [COV_W-1:0]       cv_reg;
    logic signed [CORR_W-1:0]      corr_reg;
    logic signed [REG_W-1:0]       slope_reg, icpt_reg;

    logic [WORK_W-1:0]             work_reg;
    logic [DEN_W-1:0]              den_reg;
    logic [DEN_W+1:0]              rem_reg;
    logic                          neg_reg;
    logic [IT_W-1:0]               it_reg;

    logic signed [65:0]            prod_reg;
    logic signed [32:0]            mul_a, mul_b;
    logic                          mul_en;

    logic                          m_valid_reg;
    logic [CNT_OUT_W-1:0]          o_cnt_reg;
    logic signed [MEAN_W-1:0]      o_mx_reg, o_my_reg;
    logic [VAR_W-1:0]              o_vx_reg, o_vy_reg;
    logic [SD_W-1:0]               o_sx_reg, o_sy_reg;
    logic signed [COV_W-1:0]       o_cv_reg;
    logic signed [CORR_W-1:0]      o_corr_reg;
    logic signed [REG_W-1:0]       o_slope_reg, o_icpt_reg;
    status_t                       o_status_reg;

    logic                          launch_div, launch_sqrt;
    logic signed [WORK_W-1:0]      op_a;
    logic [DEN_W-1:0]              op_d;
    logic [4:0]                    op_ret;

    logic [DEN_W:0]                div_cat;
    logic [DEN_W+1:0]              div_diff;
    logic [DEN_W+2:0]              sq_cat;
    logic [DEN_W+3:0]              sq_trial;
    logic signed [WORK_W-1:0]      div_q;
    logic signed [65:0]            prod_sh;
    logic signed [65:0]            sl_clamp;
    logic [63:0]                   cnt_ext;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign cnt_ext = 64'(cnt_reg);

    // shared multiplier operand select
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        unique case (state_reg)
            ST_ACC0: begin mul_a = 33'(x_reg);  mul_b = 33'(x_reg);  end
            ST_ACC1: begin mul_a = 33'(y_reg);  mul_b = 33'(y_reg);  end
            ST_ACC2: begin mul_a = 33'(x_reg);  mul_b = 33'(y_reg);  end
            ST_S3:   begin mul_a = 33'(mx_reg); mul_b = 33'(mx_reg); end
            ST_S4:   begin mul_a = 33'(my_reg); mul_b = 33'(my_reg); end
            ST_S5:   begin mul_a = 33'(mx_reg); mul_b = 33'(my_reg); end
            ST_S6:   begin
                mul_a = $signed(33'(vx_reg));
                mul_b = $signed(33'(vy_reg));
            end
            ST_S13:  begin mul_a = 33'(slope_reg); mul_b = 33'(mx_reg); end
            default: mul_en = 1'b0;
        endcase
    end

    // launch of the shared divide/root unit
    always_comb begin
        launch_div  = 1'b0;
        launch_sqrt = 1'b0;
        op_a        = '0;
        op_d        = '0;
        op_ret      = ST_IDLE;
        unique case (state_reg)
            ST_S1: begin
                launch_div = 1'b1;
                op_a = 64'(sum_x_reg) <<< 8; op_d = 32'(cnt_reg); op_ret = ST_S2;
            end
            ST_S2: begin
                launch_div = 1'b1;
                op_a = 64'(sum_y_reg) <<< 8; op_d = 32'(cnt_reg); op_ret = ST_S3;
            end
            ST_S3: begin
                launch_div = 1'b1;
                op_a = 64'(sum_xx_reg); op_d = 32'(cnt_reg); op_ret = ST_S4;
            end
            ST_S4: begin
                launch_div = 1'b1;
                op_a = 64'(sum_yy_reg); op_d = 32'(cnt_reg); op_ret = ST_S5;
            end
            ST_S5: begin
                launch_div = 1'b1;
                op_a = 64'(sum_xy_reg); op_d = 32'(cnt_reg); op_ret = ST_S6;
            end
            ST_S6: begin
                launch_sqrt = 1'b1;
                op_a = $signed(64'(vx_reg) << 16); op_ret = ST_S7;
            end
            ST_S7: begin
                launch_sqrt = 1'b1;
                op_a = $signed(64'(vy_reg) << 16); op_ret = ST_S8;
            end
            ST_S8: begin
                if (vx_reg != '0 && vy_reg != '0 && cnt_reg > COUNT_BITS'(1)) begin
                    launch_sqrt = 1'b1;
                    op_a = 64'(prod_reg); op_ret = ST_S9;
                end
            end
            ST_S9: begin
                launch_div = 1'b1;
                op_a = 64'(cv_reg) <<< 16; op_d = den_reg; op_ret = ST_S10;
            end
            ST_S11: begin
                if (vx_reg != '0) begin
                    launch_div = 1'b1;
                    op_a = 64'(cv_reg) <<< 16; op_d = 32'(vx_reg); op_ret = ST_S12;
                end
            end
            default: ;
        endcase
    end

    assign div_cat  = {rem_reg[DEN_W-1:0], work_reg[WORK_W-1]};
    assign div_diff = {1'b0, div_cat} - {2'b00, den_reg};
    assign sq_cat   = {rem_reg[DEN_W:0], work_reg[WORK_W-1:WORK_W-2]};
    assign sq_trial = {1'b0, sq_cat} - {2'b00, den_reg, 2'b01};
    assign div_q    = !neg_reg ? $signed(work_reg) :
                      (rem_reg != '0) ? $signed(~work_reg) : -$signed(work_reg);
    assign prod_sh  = prod_reg >>> 16;
    assign sl_clamp = clamp66(66'(div_q), I32_MIN, I32_MAX);

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= 66'(mul_a) * 66'(mul_b);
        end

        if (launch_div || launch_sqrt) begin
            neg_reg  <= launch_div && op_a[WORK_W-1];
            work_reg <= (launch_div && op_a[WORK_W-1]) ? WORK_W'(-op_a) : WORK_W'(op_a);
            den_reg  <= launch_div ? op_d : '0;
            rem_reg  <= '0;
            it_reg   <= '0;
            ret_reg  <= op_ret;
        end else if (state_reg == ST_DIV) begin
            it_reg   <= it_reg + 1'b1;
            work_reg <= {work_reg[WORK_W-2:0], ~div_diff[DEN_W+1]};
            if (!div_diff[DEN_W+1]) begin
                rem_reg <= {2'b00, div_diff[DEN_W-1:0]};
            end else begin
                rem_reg <= {2'b00, div_cat[DEN_W-1:0]};
            end
        end else if (state_reg == ST_SQRT) begin
            it_reg   <= it_reg + 1'b1;
            work_reg <= {work_reg[WORK_W-3:0], 2'b00};
            if (!sq_trial[DEN_W+3]) begin
                rem_reg <= sq_trial[DEN_W+1:0];
                den_reg <= {den_reg[DEN_W-2:0], 1'b1};
            end else begin
                rem_reg <= sq_cat[DEN_W+1:0];
                den_reg <= {den_reg[DEN_W-2:0], 1'b0};
            end
        end

        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            sum_x_reg   <= '0;
            sum_y_reg   <= '0;
            sum_xx_reg  <= '0;
            sum_yy_reg  <= '0;
            sum_xy_reg  <= '0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        x_reg     <= s_sample_x;
                        y_reg     <= s_sample_y;
                        full_reg  <= (cnt_reg == {COUNT_BITS{1'b1}});
                        state_reg <= ST_ACC0;
                    end
                end
                ST_ACC0: state_reg <= ST_ACC1;
                ST_ACC1: begin
                    if (!full_reg) sum_xx_reg <= sum_xx_reg + SXX_W'(prod_reg);
                    state_reg <= ST_ACC2;
                end
                ST_ACC2: begin
                    if (!full_reg) sum_yy_reg <= sum_yy_reg + SXX_W'(prod_reg);
                    state_reg <= ST_ACC3;
                end
                ST_ACC3: begin
                    if (!full_reg) begin
                        sum_xy_reg <= sum_xy_reg + SXX_W'(prod_reg);
                        sum_x_reg  <= sum_x_reg + SX_W'(x_reg);
                        sum_y_reg  <= sum_y_reg + SX_W'(y_reg);
                        cnt_reg    <= cnt_reg + 1'b1;
                    end
                    state_reg <= ST_S1;
                end
                ST_S1, ST_S9: state_reg <= launch_sqrt ? ST_SQRT : ST_DIV;
                ST_S2: begin
                    mx_reg    <= MEAN_W'(div_q);
                    state_reg <= ST_DIV;
                end
                ST_S3: begin
                    my_reg    <= MEAN_W'(div_q);
                    state_reg <= ST_DIV;
                end
                ST_S4: begin
                    vx_reg    <= VAR_W'(clamp66(66'(div_q) - prod_sh, '0, VAR_MAX));
                    state_reg <= ST_DIV;
                end
                ST_S5: begin
                    vy_reg    <= VAR_W'(clamp66(66'(div_q) - prod_sh, '0, VAR_MAX));
                    state_reg <= ST_DIV;
                end
                ST_S6: begin
                    cv_reg    <= COV_W'(clamp66(66'(div_q) - prod_sh, -VAR_MAX, VAR_MAX));
                    state_reg <= ST_SQRT;
                end
                ST_S7: begin
                    sx_reg    <= SD_W'(den_reg);
                    state_reg <= ST_SQRT;
                end
                ST_S8: begin
                    sy_reg <= SD_W'(den_reg);
                    if (launch_sqrt) begin
                        state_reg <= ST_SQRT;
                    end else begin
                        corr_reg  <= '0;
                        state_reg <= ST_S11;
                    end
                end
                ST_S10: begin
                    corr_reg  <= CORR_W'(clamp66(66'(div_q), -CORR_MAX, CORR_MAX));
                    state_reg <= ST_S11;
                end
                ST_S11: begin
                    if (launch_div) begin
                        state_reg <= ST_DIV;
                    end else begin
                        slope_reg <= '0;
                        icpt_reg  <= '0;
                        state_reg <= ST_DONE;
                    end
                end
                ST_S12: begin
                    slope_reg <= REG_W'(sl_clamp);
                    state_reg <= ST_S13;
                end
                ST_S13: state_reg <= ST_S14;
                ST_S14: begin
                    icpt_reg  <= REG_W'(clamp66(66'(my_reg) - prod_sh, I32_MIN, I32_MAX));
                    state_reg <= ST_DONE;
                end
                ST_DIV: begin
                    if (it_reg == IT_W'(DIV_STEPS - 1)) state_reg <= ret_reg;
                end
                ST_SQRT: begin
                    if (it_reg == IT_W'(SQRT_STEPS - 1)) state_reg <= ret_reg;
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        o_cnt_reg    <= cnt_ext[CNT_OUT_W-1:0];
                        o_mx_reg     <= mx_reg;
                        o_my_reg     <= my_reg;
                        o_vx_reg     <= vx_reg;
                        o_vy_reg     <= vy_reg;
                        o_sx_reg     <= sx_reg;
                        o_sy_reg     <= sy_reg;
                        o_cv_reg     <= cv_reg;
                        o_corr_reg   <= corr_reg;
                        o_slope_reg  <= slope_reg;
                        o_icpt_reg   <= icpt_reg;
                        if (full_reg)             o_status_reg <= STATUS_FULL;
                        else if (vx_reg == '0)    o_status_reg <= STATUS_VX_ZERO;
                        else if (vy_reg == '0)    o_status_reg <= STATUS_VY_ZERO;
                        else                      o_status_reg <= STATUS_OK;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_sample_count = o_cnt_reg;
    assign m_mean_x       = o_mx_reg;
    assign m_mean_y       = o_my_reg;
    assign m_variance_x   = o_vx_reg;
    assign m_variance_y   = o_vy_reg;
    assign m_stdev_x      = o_sx_reg;
    assign m_stdev_y      = o_sy_reg;
    assign m_covariance   = o_cv_reg;
    assign m_correlation  = o_corr_reg;
    assign m_slope        = o_slope_reg;
    assign m_intercept    = o_icpt_reg;
    assign m_status       = o_status_reg;

    `RRS_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `RRS_ASSERT_IMP(a_vx_zero_no_fit, aclk, aresetn, m_valid && m_variance_x == '0,
        m_slope == '0 && m_correlation == '0 && m_intercept == '0)
    `RRS_ASSERT_IMP(a_var_range, aclk, aresetn, m_valid,
        m_variance_x <= VAR_W'(VAR_MAX) && m_variance_y <= VAR_W'(VAR_MAX))

endmodule

FILE: tb/running_regression_stats_core_tb.sv
`timescale 1ns / 100ps

module running_regression_stats_core_tb;
    import rrs_pkg::*;

    typedef struct packed {
        logic [CNT_OUT_W-1:0]     cnt;
        logic signed [MEAN_W-1:0] mx;
        logic signed [MEAN_W-1:0] my;
        logic [VAR_W-1:0]         vx;
        logic [VAR_W-1:0]         vy;
        logic [SD_W-1:0]          sdx;
        logic [SD_W-1:0]          sdy;
        logic signed [COV_W-1:0]  cov;
        logic signed [CORR_W-1:0] corr;
        logic signed [REG_W-1:0]  slope;
        logic signed [REG_W-1:0]  icpt;
        status_t                  st;
    } stats_t;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        bit                 typed;
        stats_t             want;
    } pair_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_sample_x = '0;
    logic signed [15:0] s_sample_y = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [CNT_OUT_W-1:0] m_sample_count;
    logic signed [MEAN_W-1:0] m_mean_x, m_mean_y;
    logic [VAR_W-1:0] m_variance_x, m_variance_y;
    logic [SD_W-1:0] m_stdev_x, m_stdev_y;
    logic signed [COV_W-1:0] m_covariance;
    logic signed [CORR_W-1:0] m_correlation;
    logic signed [REG_W-1:0] m_slope, m_intercept;
    status_t m_status;

    running_regression_stats_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_sample_x(s_sample_x), .s_sample_y(s_sample_y),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_sample_count(m_sample_count), .m_mean_x(m_mean_x), .m_mean_y(m_mean_y),
        .m_variance_x(m_variance_x), .m_variance_y(m_variance_y),
        .m_stdev_x(m_stdev_x), .m_stdev_y(m_stdev_y),
        .m_covariance(m_covariance), .m_correlation(m_correlation),
        .m_slope(m_slope), .m_intercept(m_intercept), .m_status(m_status)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #40_000_000;
        $display("running_regression_stats_core_tb: errors");
        $finish;
    end

    // running sums mirrored from the block
    longint n_acc, sx_acc, sy_acc, sxx_acc, syy_acc, sxy_acc;
    stats_t pending_stats[$];
    int errors = 0;
    int checked = 0;
    int accepted = 0;
    int status_seen[4];
    bit quiet = 0;

    function automatic longint floor_div(longint a, longint d);
        longint q;
        if (d <= 0) return 0;
        q = a / d;
        if ((a % d) != 0 && a < 0) q--;
        return q;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint lim(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic stats_t accumulate_pair(logic signed [15:0] x, logic signed [15:0] y);
        stats_t r;
        longint xv, yv, mx, my, vx, vy, cv, corr, slope, icpt;
        bit full;
        xv = longint'(x);
        yv = longint'(y);
        full = (n_acc >= (64'd1 << 24) - 1);
        if (!full) begin
            n_acc++;
            sx_acc += xv;
            sy_acc += yv;
            sxx_acc += xv * xv;
            syy_acc += yv * yv;
            sxy_acc += xv * yv;
        end
        r = '0;
        if (n_acc == 0) return r;
        mx = floor_div(sx_acc * 256, n_acc);
        my = floor_div(sy_acc * 256, n_acc);
        vx = lim(floor_div(sxx_acc, n_acc) - floor_div(mx * mx, 65536), 0, 1 << 30);
        vy = lim(floor_div(syy_acc, n_acc) - floor_div(my * my, 65536), 0, 1 << 30);
        cv = lim(floor_div(sxy_acc, n_acc) - floor_div(mx * my, 65536),
                 -(64'sd1 << 30), 64'sd1 << 30);
        corr = 0;
        slope = 0;
        icpt = 0;
        if (vx != 0 && vy != 0 && n_acc >= 2)
            corr = lim(floor_div(cv * 65536, int_sqrt(vx * vy)), -65536, 65536);
        if (vx != 0) begin
            slope = lim(floor_div(cv * 65536, vx), -64'sd2147483648, 64'sd2147483647);
            icpt = lim(my - floor_div(slope * mx, 65536), -64'sd2147483648, 64'sd2147483647);
        end
        r.cnt = CNT_OUT_W'(n_acc);
        r.mx = MEAN_W'(mx);
        r.my = MEAN_W'(my);
        r.vx = VAR_W'(vx);
        r.vy = VAR_W'(vy);
        r.sdx = SD_W'(int_sqrt(vx << 16));
        r.sdy = SD_W'(int_sqrt(vy << 16));
        r.cov = COV_W'(cv);
        r.corr = CORR_W'(corr);
        r.slope = REG_W'(slope);
        r.icpt = REG_W'(icpt);
        if (full) r.st = STATUS_FULL;
        else if (vx == 0) r.st = STATUS_VX_ZERO;
        else if (vy == 0) r.st = STATUS_VY_ZERO;
        else r.st = STATUS_OK;
        return r;
    endfunction

    task automatic cmp_field(string nm, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, nm, want, got);
        end
    endtask

    // result side: checks and random back-pressure
    int stall_left = 0;
    always @(posedge aclk) begin
        stats_t w;
        if (aresetn && m_valid && m_ready) begin
            if (pending_stats.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected, expected none, got count %0d",
                         $time, m_sample_count);
            end else begin
                w = pending_stats.pop_front();
                checked++;
                status_seen[w.st]++;
                cmp_field("sample_count", 64'(w.cnt), 64'(m_sample_count));
                cmp_field("mean_x", 64'(w.mx), 64'(m_mean_x));
                cmp_field("mean_y", 64'(w.my), 64'(m_mean_y));
                cmp_field("variance_x", 64'(w.vx), 64'(m_variance_x));
                cmp_field("variance_y", 64'(w.vy), 64'(m_variance_y));
                cmp_field("stdev_x", 64'(w.sdx), 64'(m_stdev_x));
                cmp_field("stdev_y", 64'(w.sdy), 64'(m_stdev_y));
                cmp_field("covariance", 64'(w.cov), 64'(m_covariance));
                cmp_field("correlation", 64'(w.corr), 64'(m_correlation));
                cmp_field("slope", 64'(w.slope), 64'(m_slope));
                cmp_field("intercept", 64'(w.icpt), 64'(m_intercept));
                cmp_field("status", 64'(w.st), 64'(m_status));
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 12);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic offer_pair(logic signed [15:0] x, logic signed [15:0] y,
                              bit typed, stats_t want);
        stats_t p;
        s_valid <= 1'b1;
        s_sample_x <= x;
        s_sample_y <= y;
        do @(posedge aclk); while (!s_ready);
        p = accumulate_pair(x, y);
        pending_stats.push_back(typed ? want : p);
        accepted++;
        if (!quiet && $urandom_range(0, 6) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
    endtask

    function automatic logic signed [15:0] sat16(int v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return -16'sh8000;
        return 16'(v);
    endfunction

    pair_row_t rows[$];

    initial begin
        pair_row_t r;
        stats_t first;
        int x, y, k, wait_cnt;
        n_acc = 0; sx_acc = 0; sy_acc = 0; sxx_acc = 0; syy_acc = 0; sxy_acc = 0;

        // one sample: mean is the sample, everything else zero, x variance flagged
        first = '0;
        first.cnt = 24'd1;
        first.mx = -24'sd8388608;
        first.my = 24'sd1280;
        first.st = STATUS_VX_ZERO;
        rows.push_back('{-16'sh8000, 16'sd5, 1'b1, first});
        rows.push_back('{-16'sh8000, 16'sd5, 1'b0, '0});
        // x moves, y held: y variance zero
        rows.push_back('{16'sh7fff, 16'sd5, 1'b0, '0});
        rows.push_back('{16'sd0, 16'sd5, 1'b0, '0});
        rows.push_back('{16'sh7fff, 16'sh7fff, 1'b0, '0});
        rows.push_back('{-16'sh8000, -16'sh8000, 1'b0, '0});
        rows.push_back('{16'sh7fff, -16'sh8000, 1'b0, '0});
        rows.push_back('{-16'sh8000, 16'sh7fff, 1'b0, '0});
        rows.push_back('{16'sd0, 16'sd0, 1'b0, '0});
        rows.push_back('{16'sd1, -16'sd1, 1'b0, '0});
        rows.push_back('{-16'sd1, 16'sd1, 1'b0, '0});
        rows.push_back('{16'sd256, 16'sd256, 1'b0, '0});
        rows.push_back('{16'sh5555, -16'sh5556, 1'b0, '0});
        rows.push_back('{-16'sh2aab, 16'sh2aaa, 1'b0, '0});
        rows.push_back('{16'sd100, 16'sd200, 1'b0, '0});
        rows.push_back('{16'sd101, 16'sd202, 1'b0, '0});
        rows.push_back('{16'sd102, 16'sd204, 1'b0, '0});

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i])
            offer_pair(rows[i].x, rows[i].y, rows[i].typed, rows[i].want);

        for (int i = 0; i < 1500; i++) begin
            if (i == 1350) quiet = 1;
            if (i == 700) begin
                s_valid <= 1'b0;
                while (pending_stats.size() != 0) @(posedge aclk);
            end
            case ($urandom_range(0, 3))
                0: begin
                    x = $signed(16'($urandom));
                    y = $signed(16'($urandom));
                end
                1: begin
                    x = $urandom_range(0, 1024) - 512;
                    y = $urandom_range(0, 1024) - 512;
                end
                2: begin
                    k = $urandom_range(0, 16) - 8;
                    x = $urandom_range(0, 8192) - 4096;
                    y = (x * k) / 4 + $urandom_range(0, 64) - 32;
                end
                default: begin
                    x = $urandom_range(0, 1) ? 32767 : -32768;
                    y = $urandom_range(0, 1) ? x : -x;
                end
            endcase
            offer_pair(sat16(x), sat16(y), 1'b0, '0);
        end
        s_valid <= 1'b0;

        wait_cnt = 0;
        while (pending_stats.size() != 0 && wait_cnt < 100000) begin
            @(posedge aclk);
            wait_cnt++;
        end
        repeat (700) @(posedge aclk);
        if (pending_stats.size() != 0) begin
            errors++;
            $display("%0t: results missing, expected 0 outstanding, got %0d",
                     $time, pending_stats.size());
        end

        $display("%0d sample pairs sent, %0d results compared", accepted, checked);
        $display("status seen: ok %0d, x var zero %0d, y var zero %0d, full %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (errors == 0) begin
            $display("running_regression_stats_core_tb: clean");
        end else begin
            $display("running_regression_stats_core_tb: errors");
        end
        $finish;
    end
endmodule
